>>> rtl/pls_pkg.sv
// ---------------------------------------------------------------------------
// pls_pkg: shared types for the positional list store
// Request kinds, status codes and the control/status bundles that join the
// controller and the datapath.
// ---------------------------------------------------------------------------
package pls_pkg;

	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	localparam int unsigned KIND_W  = 3;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [KIND_W-1:0] {
		K_ADD_FRONT   = 3'd0,
		K_ADD_REAR    = 3'd1,
		K_REM_FRONT   = 3'd2,
		K_REM_REAR    = 3'd3,
		K_REM_AT      = 3'd4,
		K_INS_BEFORE  = 3'd5
	} pls_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} pls_status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic move;
		logic put;
		logic reply;
	} pls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip;
		logic insert;
		logic move_done;
		logic out_free;
	} pls_stat_t;

endpackage

>>> rtl/pls_req_if.sv
// ---------------------------------------------------------------------------
// pls_req_if: request channel
// Valid/ready channel carrying one list request.
// ---------------------------------------------------------------------------
interface pls_req_if;
	import pls_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

>>> rtl/pls_rsp_if.sv
// ---------------------------------------------------------------------------
// pls_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ---------------------------------------------------------------------------
interface pls_rsp_if;
	import pls_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] removed_value;
	logic [1:0]         status;
	logic [COUNT_W-1:0] element_count;
	logic               is_empty;

	modport source (output valid, removed_value, status, element_count, is_empty,
		input ready);
	modport sink   (input valid, removed_value, status, element_count, is_empty,
		output ready);
endinterface

>>> rtl/pls_ctrl.sv
// ---------------------------------------------------------------------------
// pls_ctrl: request sequencer
// Accepts a request, runs the shift sweep, an insert's write and the reply.
// ---------------------------------------------------------------------------
module pls_ctrl
	import pls_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  pls_stat_t stat,
	output pls_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MOVE  = 4'b0010,
		S_PUT   = 4'b0100,
		S_REPLY = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MOVE;
				end
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				if (stat.move_done) begin
					state_d = (stat.insert && !stat.skip) ? S_PUT : S_REPLY;
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_REPLY;
			end
			S_REPLY: begin
				if (stat.out_free) begin
					cmd.reply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/pls_datapath.sv
// ---------------------------------------------------------------------------
// pls_datapath: element store and shift engine
// Request checks, element memory with registered read, shift pointers,
// element count and the response register.
// ---------------------------------------------------------------------------
module pls_datapath
	import pls_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pls_cmd_t           cmd,
	output pls_stat_t          stat,
	input  logic [KIND_W-1:0]  kind,
	input  logic [POS_W-1:0]   position,
	input  logic [VALUE_W-1:0] value,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [VALUE_W-1:0] rsp_removed_value,
	output logic [1:0]         rsp_status,
	output logic [COUNT_W-1:0] rsp_element_count,
	output logic               rsp_is_empty
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > POS_W) ? CW + 1 : POS_W + 1;

	logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         rd_left_q;
	logic [AW-1:0]         rd_ptr_q;
	logic [AW-1:0]         pend_addr_q;
	logic                  pend_q;
	logic                  cap_q;
	logic [AW-1:0]         idx_q;
	logic                  insert_q;
	logic                  skip_q;
	pls_status_t           status_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [DATA_WIDTH-1:0] removed_q;

	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_removed_q;
	pls_status_t           out_status_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_empty_q;

	// request checks
	logic [PW-1:0]   n_ext, pos_ext;
	logic            full, empty;
	pls_status_t     ld_status;
	logic            ld_skip, ld_insert;
	logic [AW-1:0]   ld_idx;

	always_comb begin
		n_ext     = PW'(count_q);
		pos_ext   = PW'(position);
		full      = (count_q == CW'(CAPACITY));
		empty     = (count_q == '0);
		ld_status = ST_OK;
		ld_skip   = 1'b0;
		ld_insert = 1'b0;
		ld_idx    = '0;
		case (kind)
			K_ADD_FRONT: begin
				ld_insert = 1'b1;
				if (full) ld_status = ST_FULL;
			end
			K_ADD_REAR: begin
				ld_insert = 1'b1;
				ld_idx    = AW'(count_q);
				if (full) ld_status = ST_FULL;
			end
			K_REM_FRONT: begin
				if (empty) ld_status = ST_UNDER;
			end
			K_REM_REAR: begin
				ld_idx = AW'(count_q - 1'b1);
				if (empty) ld_status = ST_UNDER;
			end
			K_REM_AT: begin
				ld_idx = AW'(position - 1'b1);
				if (pos_ext == '0 || pos_ext > n_ext) ld_status = ST_RANGE;
			end
			K_INS_BEFORE: begin
				ld_insert = 1'b1;
				ld_idx    = AW'(position - 1'b1);
				if (pos_ext == '0 || pos_ext > n_ext + 1'b1) ld_status = ST_RANGE;
				else if (full) ld_status = ST_FULL;
			end
			default: begin
				ld_skip = 1'b1;
			end
		endcase
		if (ld_status != ST_OK) ld_skip = 1'b1;
	end

	// memory port selection
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_wa;
	logic [DATA_WIDTH-1:0] mem_wd;

	always_comb begin
		mem_re = cmd.move && (rd_left_q != '0);
		mem_we = 1'b0;
		mem_wa = pend_addr_q;
		mem_wd = rdata_q;
		if (cmd.move && pend_q && !cap_q) begin
			mem_we = 1'b1;
		end else if (cmd.put) begin
			mem_we = 1'b1;
			mem_wa = idx_q;
			mem_wd = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= mem_q[rd_ptr_q];
	end

	// request register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q     <= ld_idx;
			insert_q  <= ld_insert;
			skip_q    <= ld_skip;
			status_q  <= ld_status;
			value_q   <= DATA_WIDTH'(value);
			removed_q <= '0;
		end else if (cmd.move && pend_q && cap_q) begin
			removed_q <= rdata_q;
		end
	end

	// shift sweep: insert walks down from the rear, remove walks up from idx
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_left_q   <= '0;
			rd_ptr_q    <= '0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			cap_q       <= 1'b0;
		end else if (cmd.load) begin
			rd_left_q   <= ld_skip ? '0 : count_q - CW'(ld_idx);
			rd_ptr_q    <= ld_insert ? AW'(count_q - 1'b1) : ld_idx;
			pend_q      <= 1'b0;
			cap_q       <= !ld_insert && !ld_skip;
		end else if (cmd.move) begin
			if (pend_q) cap_q <= 1'b0;
			if (rd_left_q != '0) begin
				rd_left_q   <= rd_left_q - 1'b1;
				rd_ptr_q    <= insert_q ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
				pend_addr_q <= insert_q ? rd_ptr_q + 1'b1 : rd_ptr_q - 1'b1;
				pend_q      <= 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	// count and response register
	logic [CW-1:0] new_count;

	always_comb begin
		if (skip_q) new_count = count_q;
		else if (insert_q) new_count = count_q + 1'b1;
		else new_count = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.reply) begin
				count_q     <= new_count;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			out_removed_q <= VALUE_W'(removed_q);
			out_status_q  <= status_q;
			out_count_q   <= COUNT_W'(new_count);
			out_empty_q   <= (new_count == '0);
		end
	end

	assign stat.skip      = skip_q;
	assign stat.insert    = insert_q;
	assign stat.move_done = (rd_left_q == '0) && !pend_q;
	assign stat.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid         = out_valid_q;
	assign rsp_removed_value = out_removed_q;
	assign rsp_status        = out_status_q;
	assign rsp_element_count = out_count_q;
	assign rsp_is_empty      = out_empty_q;

endmodule

>>> rtl/positional_list_store.sv
// Sequence: a taken request is loaded, the shift sweep moves the entries behind its
// position (remove at rear and add at rear move none), an add or insert then writes
// its value, and the response is registered; a refused or no-op request moves nothing.
// One request at a time: the next is taken the cycle after the response is registered,
// and the reply waits while an earlier response is still held.
// Reset clears the element count and the handshakes; store contents are not cleared.
// ---------------------------------------------------------------------------
// positional_list_store: bounded ordered list with positional edits
// Controller and datapath joined by command and status bundles.
// ---------------------------------------------------------------------------
module positional_list_store
	import pls_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pls_req_if.sink   req,
	pls_rsp_if.source rsp
);

	pls_cmd_t  cmd;
	pls_stat_t stat;

	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pls_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.kind              (req.kind),
		.position          (req.position),
		.value             (req.value),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_removed_value (rsp.removed_value),
		.rsp_status        (rsp.status),
		.rsp_element_count (rsp.element_count),
		.rsp_is_empty      (rsp.is_empty)
	);

endmodule

>>> rtl/pls_checker.sv
// ---------------------------------------------------------------------------
// pls_checker: port-level checks for the positional list store
// Response consistency and one-request-at-a-time acceptance.
// ---------------------------------------------------------------------------
module pls_checker
	import pls_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [VALUE_W-1:0] removed_value,
	input logic [1:0]         status,
	input logic [COUNT_W-1:0] element_count,
	input logic               is_empty
);

	// a waiting response stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before being taken");

	// a request in work blocks the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request accepted while one is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (element_count == '0)))
		else $error("empty flag disagrees with count");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> removed_value == '0)
		else $error("failed request reports a removed value");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_UNDER |-> is_empty)
		else $error("underflow reported on a non-empty list");

endmodule

bind positional_list_store pls_checker u_pls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.removed_value (rsp.removed_value),
	.status        (rsp.status),
	.element_count (rsp.element_count),
	.is_empty      (rsp.is_empty)
);

>>> bench/pls_list_checker.sv
// ---------------------------------------------------------------------------
// pls_list_checker: response checker for the positional list store
// Keeps its own copy of the list, and works out the expected response when
// a request is taken. Responses are compared field by field with the oldest
// expected response, in order.
// ---------------------------------------------------------------------------
module pls_list_checker
	import pls_pkg::*;
#(
	parameter int unsigned LIST_DEPTH = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pls_req_if   req,
	pls_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [VALUE_W-1:0] removed;
		pls_status_t        status;
		logic [COUNT_W-1:0] count;
		logic               empty;
	} list_outcome_t;

	logic [VALUE_W-1:0] list_entries[$];
	list_outcome_t      outcome_q[$];
	list_outcome_t      oldest;
	int                 fail_count = 0;

	assign errors = fail_count;

	// Applies one request to the local list and returns the response it must give.
	function automatic list_outcome_t apply_request(logic [KIND_W-1:0] kind,
		logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
		list_outcome_t res;
		int unsigned   held;
		res.removed = '0;
		res.status  = ST_OK;
		held = list_entries.size();
		case (kind)
			K_ADD_FRONT, K_ADD_REAR: begin
				if (held >= LIST_DEPTH)
					res.status = ST_FULL;
				else if (kind == K_ADD_FRONT)
					list_entries.push_front(val);
				else
					list_entries.push_back(val);
			end
			K_REM_FRONT: begin
				if (held == 0)
					res.status = ST_UNDER;
				else
					res.removed = list_entries.pop_front();
			end
			K_REM_REAR: begin
				if (held == 0)
					res.status = ST_UNDER;
				else
					res.removed = list_entries.pop_back();
			end
			K_REM_AT: begin
				if (pos == 0 || pos > held) begin
					res.status = ST_RANGE;
				end else begin
					res.removed = list_entries[pos - 1];
					list_entries.delete(pos - 1);
				end
			end
			K_INS_BEFORE: begin
				// range is tested ahead of full
				if (pos == 0 || pos > held + 1)
					res.status = ST_RANGE;
				else if (held >= LIST_DEPTH)
					res.status = ST_FULL;
				else
					list_entries.insert(pos - 1, val);
			end
			default: ;
		endcase
		res.count = COUNT_W'(list_entries.size());
		res.empty = (list_entries.size() == 0);
		return res;
	endfunction

	function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_entries.delete();
			outcome_q.delete();
			pending <= 0;
		end else begin
			// a response always belongs to an earlier request, so retire first
			if (rsp.valid && rsp.ready) begin
				if (outcome_q.size() == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					oldest = outcome_q.pop_front();
					match_field("removed_value", oldest.removed, rsp.removed_value);
					match_field("status", oldest.status, rsp.status);
					match_field("element_count", oldest.count, rsp.element_count);
					match_field("is_empty", oldest.empty, rsp.is_empty);
				end
			end
			if (req.valid && req.ready)
				outcome_q.push_back(apply_request(req.kind, req.position, req.value));
			pending <= outcome_q.size();
		end
	end

endmodule

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: top level for the positional list store
// Directed requests cover empty, full and bad-position cases, then random
// requests in grow and shrink phases walk the list between empty and full,
// with random gaps on both channels. A checker predicts every response.
// ---------------------------------------------------------------------------
module testbench;
	import pls_pkg::*;

	localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;
	localparam int                PHASES     = 14;
	localparam int                PHASE_LEN  = 50;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	bit   sender_calm = 1'b0;

	pls_req_if req_ch ();
	pls_rsp_if rsp_ch ();

	positional_list_store DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pls_list_checker CHK (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (fail_count),
		.pending (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// response side stalls, quiet while the sender is
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sender_calm)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(0, 99) >= 8);
		end
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
		input logic [VALUE_W-1:0] val);
		while (!sender_calm && $urandom_range(0, 99) < 8) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= kind;
		req_ch.position <= pos;
		req_ch.value    <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 16)
			return '1;
		return $urandom;
	endfunction

	initial begin
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		int                grow;
		int                r;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.kind     <= K_ADD_FRONT;
		req_ch.position <= '0;
		req_ch.value    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases, spare kinds, then edits on a short list
		send_request(K_REM_FRONT, 5'd0, 32'h0);
		send_request(K_REM_REAR, 5'd0, 32'h0);
		send_request(K_REM_AT, 5'd0, 32'h0);
		send_request(K_REM_AT, 5'd1, 32'h0);
		send_request(K_INS_BEFORE, 5'd0, 32'h1234_5678);
		send_request(K_INS_BEFORE, 5'd2, 32'h1234_5678);
		send_request(K_INS_BEFORE, 5'd1, 32'hFFFF_FFFF);
		send_request(K_SPARE_LO, 5'd1, 32'hDEAD_BEEF);
		send_request(K_SPARE_HI, 5'd31, 32'hFFFF_FFFF);
		send_request(K_REM_AT, 5'd1, 32'h0);
		send_request(K_ADD_FRONT, 5'd0, 32'h0);
		send_request(K_ADD_REAR, 5'd31, 32'hFFFF_FFFF);
		send_request(K_INS_BEFORE, 5'd3, 32'hA5A5_5A5A);
		send_request(K_REM_AT, 5'd2, 32'h0);
		// fill to capacity, then hit the full cases
		for (int k = 0; k < CAPACITY_DEF - 2; k++) begin
			case (k % 3)
				0: send_request(K_ADD_FRONT, 5'd0, $urandom);
				1: send_request(K_ADD_REAR, 5'd0, $urandom);
				default: send_request(K_INS_BEFORE, 5'(k % 3 + 1), $urandom);
			endcase
		end
		send_request(K_ADD_FRONT, 5'd0, 32'h1111_1111);
		send_request(K_ADD_REAR, 5'd0, 32'h2222_2222);
		send_request(K_INS_BEFORE, 5'd17, 32'h3333_3333);
		send_request(K_INS_BEFORE, 5'd18, 32'h4444_4444);
		send_request(K_REM_AT, 5'd16, 32'h0);
		send_request(K_REM_AT, 5'd31, 32'h0);

		// alternate grow and shrink phases so the list swings full to empty
		for (int ph = 0; ph < PHASES; ph++) begin
			grow = (ph % 2 == 0) ? 72 : 28;
			for (int n = 0; n < PHASE_LEN; n++) begin
				sender_calm = (ph == 6 || ph == 7);
				r = $urandom_range(0, 99);
				if ($urandom_range(0, 99) < 90)
					pos = 5'($urandom_range(0, CAPACITY_DEF + 1));
				else
					pos = 5'($urandom_range(0, 31));
				if (r < 2)
					kind = $urandom_range(0, 1) ? K_SPARE_HI : K_SPARE_LO;
				else if (r < 2 + grow)
					case ($urandom_range(0, 2))
						0: kind = K_ADD_FRONT;
						1: kind = K_ADD_REAR;
						default: kind = K_INS_BEFORE;
					endcase
				else
					case ($urandom_range(0, 2))
						0: kind = K_REM_FRONT;
						1: kind = K_REM_REAR;
						default: kind = K_REM_AT;
					endcase
				send_request(kind, pos, pick_value());
			end
		end
		sender_calm = 1'b0;
		req_ch.valid <= 1'b0;

		// let the count of the last request settle before polling it
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (CAPACITY_DEF + 8) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pls_pkg.sv
rtl/pls_req_if.sv
rtl/pls_rsp_if.sv
rtl/pls_ctrl.sv
rtl/pls_datapath.sv
rtl/positional_list_store.sv
rtl/pls_checker.sv
bench/pls_list_checker.sv
bench/testbench.sv
